FILE: hdl/coh_pkg.sv
// coh_pkg: shared types, constants and helpers of the orbit histogram block.
// Holds the multiply op codes, the command and status structs that join the
// controller and the datapath, and the package constants for the defaults.
package coh_pkg;

    localparam int GRID_X_DEF    = 256;
    localparam int GRID_Y_DEF    = 256;
    localparam int FRAC_BITS_DEF = 28;

    localparam int IN_W    = 31;   // Q3.28 input fields
    localparam int IN_FRAC = 28;
    localparam int RD_W    = 8;    // read_x / read_y
    localparam int CNT_W   = 11;   // max_iter, steps_done
    localparam int BIN_W   = 32;

    localparam logic [CNT_W-1:0] MAX_ITER_RST = 11'd1000;
    localparam logic [CNT_W-1:0] LIM_MIN      = 11'd2;
    localparam logic [CNT_W-1:0] LIM_MAX      = 11'd1024;

    // round(2^40 / sqrt 2), used to map the imaginary part onto rows
    localparam int               INV_SH        = 40;
    localparam logic [39:0]      INV_SQRT2_Q40 = 40'd777472127994;

    // one code per multiply in the iteration and binning sequence
    typedef enum logic [3:0] {
        M_ZRWR, M_ZIWI, M_ZRWI, M_ZIWR,
        M_RRTR, M_RITI, M_RRTI, M_RITR,
        M_SQRE, M_SQIM, M_BIN
    } t_mop;

    typedef struct packed {
        logic load;
        logic prep_w;
        logic mul_start;
        logic rnd;
        logic wb;
        logic commit;
        logic set_esc;
        logic bin_addr;
        logic mem_rd;
        logic mem_wr;
        logic rd_req;
        logic clr_wr;
        logic resp_load;
        t_mop mop;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic coarse_esc;
        logic fine_esc;
        logic at_lim;
        logic clear_done;
        logic req_read;
    } t_stat;

    // order of the products within one iteration of the map
    function automatic t_mop mop_next(input t_mop m);
        t_mop r;
        case (m)
            M_ZRWR:  r = M_ZIWI;
            M_ZIWI:  r = M_ZRWI;
            M_ZRWI:  r = M_ZIWR;
            M_ZIWR:  r = M_RRTR;
            M_RRTR:  r = M_RITI;
            M_RITI:  r = M_RRTI;
            M_RRTI:  r = M_RITR;
            M_SQRE:  r = M_SQIM;
            default: r = M_ZRWR;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/coh_mul.sv
// coh_mul: unsigned multiplier shared by every product of the block.
// Splits both operands into halves and accumulates four partial products.
// Stand-alone, no package use.
module coh_mul #(
    parameter int OP_W = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [OP_W-1:0]                i_a,
    input  logic [OP_W-1:0]                i_b,
    output logic                           o_done,
    output logic [4*((OP_W+1)/2)-1:0]      o_p
);
    localparam int H  = (OP_W + 1) / 2;
    localparam int PW = 4 * H;

    logic [2*H-1:0] r_a, r_b, r_pp;
    logic [1:0]     r_k, r_pps;
    logic           r_busy, r_ppv, r_done;
    logic [PW-1:0]  r_acc;

    logic [H-1:0]   ha, hb;
    logic [2*H-1:0] n_pp;
    logic [PW-1:0]  pp_sh;

    always_comb begin
        ha   = r_k[1] ? r_a[2*H-1:H] : r_a[H-1:0];
        hb   = r_k[0] ? r_b[2*H-1:H] : r_b[H-1:0];
        n_pp = ha * hb;
        case (r_pps)
            2'd0:    pp_sh = PW'(r_pp);
            2'd3:    pp_sh = PW'(r_pp) << (2 * H);
            default: pp_sh = PW'(r_pp) << H;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            r_done <= r_ppv && (r_pps == 2'd3);
            r_ppv  <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 2'd0;
            end else if (r_busy) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= (2*H)'(i_a);
            r_b   <= (2*H)'(i_b);
            r_acc <= '0;
        end else if (r_ppv) begin
            r_acc <= r_acc + pp_sh;
        end
        if (r_busy) begin
            r_pp  <= n_pp;
            r_pps <= r_k;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

FILE: hdl/coh_datapath.sv
// coh_datapath: orbit registers, product rounding, bin mapping, histogram
// memory and result registers. Uses coh_pkg and instantiates coh_mul.
module coh_datapath #(
    parameter int GRID_X    = coh_pkg::GRID_X_DEF,
    parameter int GRID_Y    = coh_pkg::GRID_Y_DEF,
    parameter int FRAC_BITS = coh_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  coh_pkg::t_cmd                       i_cmd,
    output coh_pkg::t_stat                      o_stat,
    input  logic                                i_cfg_we,
    input  logic [coh_pkg::CNT_W-1:0]           i_cfg_data,
    input  logic                                i_req_type,
    input  logic signed [coh_pkg::IN_W-1:0]     i_param_re,
    input  logic signed [coh_pkg::IN_W-1:0]     i_param_im,
    input  logic signed [coh_pkg::IN_W-1:0]     i_start_re,
    input  logic signed [coh_pkg::IN_W-1:0]     i_start_im,
    input  logic [coh_pkg::RD_W-1:0]            i_read_x,
    input  logic [coh_pkg::RD_W-1:0]            i_read_y,
    output logic                                o_resp_kind,
    output logic [coh_pkg::CNT_W-1:0]           o_steps_done,
    output logic                                o_escaped,
    output logic [coh_pkg::BIN_W-1:0]           o_bin_count
);
    import coh_pkg::*;

    localparam int W     = FRAC_BITS + 8;
    localparam int SW    = W + 2;
    localparam int MW    = (FRAC_BITS + 7 > INV_SH) ? FRAC_BITS + 7 : INV_SH;
    localparam int PW    = 4 * ((MW + 1) / 2);
    localparam int EW    = W + 14;
    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam int DEPTH = GRID_X * GRID_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int UP    = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
    localparam int DN    = (FRAC_BITS >= IN_FRAC) ? 0 : IN_FRAC - FRAC_BITS;

    localparam longint ZLIM_L = (longint'(1) <<< (FRAC_BITS + 7)) - 1;
    localparam longint ONE_L  = longint'(1) <<< FRAC_BITS;
    localparam longint OFFY_L = (longint'(35) <<< FRAC_BITS) / 100;

    localparam logic signed [SW-1:0]   ZLIM_S = SW'(ZLIM_L);
    localparam logic [PW-1:0]          ZLIM_U = PW'(ZLIM_L);
    localparam logic signed [SW-1:0]   ONE_S  = SW'(ONE_L);
    localparam logic signed [W-1:0]    TWO_S  = W'(2 * ONE_L);
    localparam logic signed [W:0]      HALF_S = (W+1)'(ONE_L / 2);
    localparam logic signed [W:0]      OFFY_S = (W+1)'(OFFY_L);
    localparam logic [PW:0]            FOUR_U = (PW+1)'(1) << (2 * FRAC_BITS + 2);
    localparam logic signed [EW-1:0]   GX_S   = EW'(GRID_X);
    localparam logic signed [EW-1:0]   GY_S   = EW'(GRID_Y);

    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
        logic signed [W-1:0] r;
        if (v > ZLIM_S) begin
            r = W'(ZLIM_S);
        end else if (v < -ZLIM_S) begin
            r = W'(-ZLIM_S);
        end else begin
            r = W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] scale_in(input logic signed [IN_W-1:0] v);
        logic signed [W-1:0] e;
        e = W'(v);
        return (FRAC_BITS >= IN_FRAC) ? (e <<< UP) : (e >>> DN);
    endfunction

    function automatic logic [MW-1:0] mag_w(input logic signed [W-1:0] v);
        logic [W-1:0] m;
        m = v[W-1] ? W'(-v) : W'(v);
        return MW'(m[W-2:0]);
    endfunction

    // orbit and working registers
    logic signed [W-1:0] r_rr, r_ri, r_zr, r_zi, r_wr, r_wi, r_tr, r_ti, r_nr, r_ni;
    logic signed [W-1:0] r_acc, r_q;
    logic signed [W:0]   r_vy;
    logic [PW-1:0]       r_sq;
    logic                r_neg, r_fesc, r_kind, r_esc;
    logic [RD_W-1:0]     r_rx, r_ry;
    logic [CNT_W-1:0]    r_cnt, r_max;
    logic [XW-1:0]       r_bx;
    logic [YW-1:0]       r_by;
    logic                r_bok, r_rok;
    logic [AW-1:0]       r_clr;
    logic [BIN_W-1:0]    r_rd;
    logic [BIN_W-1:0]    mem [DEPTH];

    logic                r_o_kind, r_o_esc;
    logic [CNT_W-1:0]    r_o_steps;
    logic [BIN_W-1:0]    r_o_bin;

    // multiplier operands
    logic signed [W-1:0] op_a, op_b;
    logic [MW-1:0]       a_mag, b_mag;
    logic                n_neg;
    logic                mul_done;
    logic [PW-1:0]       mul_p;

    always_comb begin
        case (i_cmd.mop)
            M_ZRWR:  begin op_a = r_zr; op_b = r_wr; end
            M_ZIWI:  begin op_a = r_zi; op_b = r_wi; end
            M_ZRWI:  begin op_a = r_zr; op_b = r_wi; end
            M_ZIWR:  begin op_a = r_zi; op_b = r_wr; end
            M_RRTR:  begin op_a = r_rr; op_b = r_tr; end
            M_RITI:  begin op_a = r_ri; op_b = r_ti; end
            M_RRTI:  begin op_a = r_rr; op_b = r_ti; end
            M_RITR:  begin op_a = r_ri; op_b = r_tr; end
            M_SQRE:  begin op_a = r_nr; op_b = r_nr; end
            M_SQIM:  begin op_a = r_ni; op_b = r_ni; end
            default: begin op_a = r_zi; op_b = '0;   end
        endcase
        a_mag = mag_w(op_a);
        if (i_cmd.mop == M_BIN) begin
            b_mag = MW'(INV_SQRT2_Q40);
            n_neg = op_a[W-1];
        end else begin
            b_mag = mag_w(op_b);
            n_neg = op_a[W-1] ^ op_b[W-1];
        end
    end

    coh_mul #(.OP_W(MW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (a_mag),
        .i_b     (b_mag),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // floor of the scaled product, saturated, with the sign restored
    logic [PW-1:0]       p_sh, p_inc;
    logic                p_rem;
    logic [W-1:0]        q_mag;
    always_comb begin
        if (i_cmd.mop == M_BIN) begin
            p_sh  = mul_p >> INV_SH;
            p_rem = |mul_p[INV_SH-1:0];
        end else begin
            p_sh  = mul_p >> FRAC_BITS;
            p_rem = |mul_p[FRAC_BITS-1:0];
        end
        p_inc = p_sh + PW'(r_neg && p_rem);
        q_mag = (p_inc > ZLIM_U) ? W'(ZLIM_U) : p_inc[W-1:0];
    end

    // bin mapping
    logic signed [W:0]    vx;
    logic signed [EW-1:0] xs, ys;
    logic [PW:0]          sq_sum;
    logic [AW-1:0]        baddr, raddr, maddr;
    logic [CNT_W-1:0]     lim;
    logic [BIN_W-1:0]     rd_inc;

    always_comb begin
        vx     = (W+1)'(r_zr) + HALF_S;
        xs     = (EW'(vx) * GX_S) >>> FRAC_BITS;
        ys     = (EW'(r_vy) * GY_S) >>> FRAC_BITS;
        sq_sum = (PW+1)'(r_sq) + (PW+1)'(mul_p);
        baddr  = AW'(r_bx) * AW'(GRID_Y) + AW'(r_by);
        raddr  = AW'(r_rx) * AW'(GRID_Y) + AW'(r_ry);
        if (i_cmd.clr_wr) begin
            maddr = r_clr;
        end else if (i_cmd.rd_req) begin
            maddr = raddr;
        end else begin
            maddr = baddr;
        end
        if (r_max < LIM_MIN) begin
            lim = LIM_MIN;
        end else if (r_max > LIM_MAX) begin
            lim = LIM_MAX;
        end else begin
            lim = r_max;
        end
        rd_inc = (r_rd == '1) ? r_rd : r_rd + BIN_W'(1);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_ITER_RST;
            r_clr <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.load) begin
                r_cnt <= CNT_W'(1);
            end else if (i_cmd.commit) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req_type;
            r_rr   <= scale_in(i_param_re);
            r_ri   <= scale_in(i_param_im);
            r_zr   <= scale_in(i_start_re);
            r_zi   <= scale_in(i_start_im);
            r_rx   <= i_read_x;
            r_ry   <= i_read_y;
            r_esc  <= 1'b0;
        end
        if (i_cmd.set_esc) begin
            r_esc <= 1'b1;
        end
        if (i_cmd.prep_w) begin
            r_wr <= sat_w(ONE_S - SW'(r_zr));
            r_wi <= sat_w(-SW'(r_zi));
        end
        if (i_cmd.mul_start) begin
            r_neg <= n_neg;
        end
        if (i_cmd.rnd) begin
            r_q <= r_neg ? W'(-q_mag) : W'(q_mag);
        end
        if (i_cmd.wb) begin
            case (i_cmd.mop)
                M_ZIWI:  r_tr <= sat_w(SW'(r_acc) - SW'(r_q));
                M_ZIWR:  r_ti <= sat_w(SW'(r_acc) + SW'(r_q));
                M_RITI:  r_nr <= sat_w(SW'(r_acc) - SW'(r_q));
                M_RITR:  r_ni <= sat_w(SW'(r_acc) + SW'(r_q));
                M_SQRE:  r_sq <= mul_p;
                M_SQIM:  r_fesc <= sq_sum > FOUR_U;
                M_BIN:   r_vy <= (W+1)'(r_q) + OFFY_S;
                default: r_acc <= r_q;
            endcase
        end
        if (i_cmd.commit) begin
            r_zr <= r_nr;
            r_zi <= r_ni;
        end
        if (i_cmd.bin_addr) begin
            r_bok <= !vx[W] && !r_vy[W] && (xs < GX_S) && (ys < GY_S);
            r_bx  <= xs[XW-1:0];
            r_by  <= ys[YW-1:0];
        end
        if (i_cmd.rd_req) begin
            r_rok <= (int'(r_rx) < GRID_X) && (int'(r_ry) < GRID_Y);
        end
        if (i_cmd.resp_load) begin
            r_o_kind  <= r_kind;
            r_o_steps <= r_kind ? '0 : r_cnt;
            r_o_esc   <= r_kind ? 1'b0 : r_esc;
            r_o_bin   <= (r_kind && r_rok) ? r_rd : '0;
        end
    end

    // histogram memory, one port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem[maddr] <= '0;
        end else if (i_cmd.mem_wr && r_bok) begin
            mem[maddr] <= rd_inc;
        end
        if (i_cmd.mem_rd || i_cmd.rd_req) begin
            r_rd <= mem[maddr];
        end
    end

    always_comb begin
        o_stat.mul_done   = mul_done;
        o_stat.coarse_esc = (r_nr > TWO_S) || (r_nr < -TWO_S)
                         || (r_ni > TWO_S) || (r_ni < -TWO_S);
        o_stat.fine_esc   = r_fesc;
        o_stat.at_lim     = (r_cnt == lim);
        o_stat.clear_done = (r_clr == AW'(DEPTH - 1));
        o_stat.req_read   = r_kind;
    end

    assign o_resp_kind  = r_o_kind;
    assign o_steps_done = r_o_steps;
    assign o_escaped    = r_o_esc;
    assign o_bin_count  = r_o_bin;

endmodule

FILE: hdl/coh_ctrl.sv
// coh_ctrl: sequencer of the orbit histogram block.
// Steps the datapath through clear, load, products, escape test, binning and
// response. Uses coh_pkg for the command and status structs.
module coh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output coh_pkg::t_cmd   o_cmd,
    input  coh_pkg::t_stat  i_stat
);
    import coh_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_DISP  = 15'b000000000000100,
        S_PREPW = 15'b000000000001000,
        S_MUL   = 15'b000000000010000,
        S_WAIT  = 15'b000000000100000,
        S_RND   = 15'b000000001000000,
        S_WB    = 15'b000000010000000,
        S_ESC   = 15'b000000100000000,
        S_ESC2  = 15'b000001000000000,
        S_BADR  = 15'b000010000000000,
        S_BRD   = 15'b000100000000000,
        S_BWR   = 15'b001000000000000,
        S_RRD   = 15'b010000000000000,
        S_RESP  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    t_mop   r_mop, n_mop;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_mop   = r_mop;
        o_cmd   = '0;
        o_cmd.mop = r_mop;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.req_read) begin
                    n_state = S_RRD;
                end else begin
                    n_mop   = M_BIN;
                    n_state = S_MUL;
                end
            end
            S_PREPW: begin
                o_cmd.prep_w = 1'b1;
                n_mop   = M_ZRWR;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.mul_done) n_state = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                case (r_mop)
                    M_RITR:  n_state = S_ESC;
                    M_SQIM:  n_state = S_ESC2;
                    M_BIN:   n_state = S_BADR;
                    default: begin
                        n_mop   = mop_next(r_mop);
                        n_state = S_MUL;
                    end
                endcase
            end
            S_ESC: begin
                if (i_stat.coarse_esc) begin
                    o_cmd.set_esc = 1'b1;
                    n_state = S_RESP;
                end else begin
                    n_mop   = M_SQRE;
                    n_state = S_MUL;
                end
            end
            S_ESC2: begin
                if (i_stat.fine_esc) begin
                    o_cmd.set_esc = 1'b1;
                    n_state = S_RESP;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_mop   = M_BIN;
                    n_state = S_MUL;
                end
            end
            S_BADR: begin
                o_cmd.bin_addr = 1'b1;
                n_state = S_BRD;
            end
            S_BRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_BWR;
            end
            S_BWR: begin
                o_cmd.mem_wr = 1'b1;
                n_state = i_stat.at_lim ? S_RESP : S_PREPW;
            end
            S_RRD: begin
                o_cmd.rd_req = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.resp_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        if (o_cmd.resp_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_mop       <= M_ZRWR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mop       <= n_mop;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/complex_orbit_histogram.sv
// complex_orbit_histogram: top level of the orbit histogram block.
// Joins coh_ctrl and coh_datapath (with coh_mul); uses coh_pkg.
//
// Usage
//   Request channel (i_in_valid / o_in_stall): req_type 0 runs one trajectory
//   of z -> r*z*(1-z) from start point z0, binning z0 and every iterate that
//   stays within magnitude 2 into a GRID_X by GRID_Y histogram of saturating
//   counters; req_type 1 reads one bin. One request is in work at a time.
//   Response channel (o_out_valid / i_out_stall): exactly one transaction per
//   request. An output register holds a finished response, so the next
//   request is taken while it waits; a stalled receiver only holds the block
//   once the following response is ready.
//   Sequence: a bin read goes from dispatch through a memory read to the
//   response register. For a trajectory, each iterate needs eleven products
//   on the one shared multiplier, each built from four partial products,
//   plus rounding, write-back and a memory read-modify-write of the
//   histogram's single port.
//   Reset: the histogram is cleared by a pass over all GRID_X * GRID_Y
//   entries, one a cycle; no request is taken meanwhile, but max_iter writes
//   (i_cfg_we / i_cfg_data) are.
module complex_orbit_histogram #(
    parameter int GRID_X    = coh_pkg::GRID_X_DEF,
    parameter int GRID_Y    = coh_pkg::GRID_Y_DEF,
    parameter int FRAC_BITS = coh_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [coh_pkg::CNT_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic signed [coh_pkg::IN_W-1:0]     i_param_re,
    input  logic signed [coh_pkg::IN_W-1:0]     i_param_im,
    input  logic signed [coh_pkg::IN_W-1:0]     i_start_re,
    input  logic signed [coh_pkg::IN_W-1:0]     i_start_im,
    input  logic [coh_pkg::RD_W-1:0]            i_read_x,
    input  logic [coh_pkg::RD_W-1:0]            i_read_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_resp_kind,
    output logic [coh_pkg::CNT_W-1:0]           o_steps_done,
    output logic                                o_escaped,
    output logic [coh_pkg::BIN_W-1:0]           o_bin_count
);
    import coh_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: owns both handshakes and the step order
    coh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // arithmetic, histogram memory and response payload
    coh_datapath #(
        .GRID_X    (GRID_X),
        .GRID_Y    (GRID_Y),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (i_req_type),
        .i_param_re   (i_param_re),
        .i_param_im   (i_param_im),
        .i_start_re   (i_start_re),
        .i_start_im   (i_start_im),
        .i_read_x     (i_read_x),
        .i_read_y     (i_read_y),
        .o_resp_kind  (o_resp_kind),
        .o_steps_done (o_steps_done),
        .o_escaped    (o_escaped),
        .o_bin_count  (o_bin_count)
    );

    // a response is never loaded over one the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.resp_load |-> !(o_out_valid && i_out_stall))
        else $error("response overwritten while stalled");

    // the datapath captures a request only on an accepted transaction
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (i_in_valid && !o_in_stall))
        else $error("request captured without a transaction");

    // no request is taken during the clearing pass
    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_wr |-> o_in_stall)
        else $error("request accepted during histogram clear");

    // a new response appears only after a load of the output register
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.resp_load))
        else $error("response valid without a load");

endmodule
